@@ src/mphp_pkg.sv @@
package mphp_pkg;

    // Largest number of bytes of one packet that are parsed; later bytes are tagged with the discard role.
    localparam int unsigned MAX_PACKET_BYTES_DEF = 256;

    // Path byte limit after reset.
    localparam logic [7:0] MAX_PATH_BYTES_RST = 8'd64;

    // Header fields
    localparam logic [1:0] ROUTE_TRANSPORT_A = 2'd0;
    localparam logic [1:0] ROUTE_TRANSPORT_B = 2'd3;
    localparam logic [1:0] VERSION_SUPPORTED = 2'd0;
    localparam logic [1:0] HASH_SIZE_BAD     = 2'd3;  // hash size 4 in the size-minus-one code

    // Parse phase. A byte is tagged with the phase it is parsed in, so the
    // phase code is also the byte role code.
    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TRANSPORT = 3'd1,
        PH_PATHLEN   = 3'd2,
        PH_PATH      = 3'd3,
        PH_PAYLOAD   = 3'd4,
        PH_DISCARD   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_VERSION = 2'd2,
        ST_BADPATH = 2'd3
    } t_status;

    // One byte transaction held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] byte_value;
        logic       packet_end;
    } t_beat;

endpackage

@@ src/mphp_in_stage.sv @@
module mphp_in_stage import mphp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_packet_end,
    input  logic       i_take,
    output t_beat      o_beat
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       w_accept;

    // Free when empty or when the held byte is consumed this cycle.
    assign o_in_stall = r_valid && !i_take;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte_value;
            r_end  <= i_packet_end;
        end
    end

    assign o_beat.valid      = r_valid;
    assign o_beat.byte_value = r_byte;
    assign o_beat.packet_end = r_end;

endmodule

@@ src/mphp_parser.sv @@
module mphp_parser import mphp_pkg::*; #(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_beat       i_beat,
    output logic        o_take,
    input  logic [7:0]  i_max_path_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_byte_role,
    output logic [7:0]  o_byte_out,
    output logic [1:0]  o_route_kind,
    output logic [3:0]  o_payload_kind,
    output logic [5:0]  o_hash_count,
    output logic [2:0]  o_hash_size,
    output logic [15:0] o_code_one,
    output logic [15:0] o_code_two,
    output logic        o_frame_done,
    output logic [1:0]  o_status
);

    localparam int unsigned TW = $clog2(MAX_PACKET_BYTES + 1);

    // Parse state
    t_phase        r_phase;
    t_phase        n_phase;
    logic [TW-1:0] r_byte_total;
    logic [TW-1:0] n_byte_total;
    logic [7:0]    r_header;
    logic [7:0]    n_header;
    logic [15:0]   r_code_one;
    logic [15:0]   n_code_one;
    logic [15:0]   r_code_two;
    logic [15:0]   n_code_two;
    logic [7:0]    r_path_len;
    logic [7:0]    n_path_len;
    logic [7:0]    r_path_left;
    logic [7:0]    n_path_left;
    t_status       r_pending;
    t_status       n_pending;

    // Result register
    logic          r_out_valid;
    logic          n_out_valid;
    logic [2:0]    r_role;
    logic [7:0]    r_byte;
    logic          r_end;
    t_status       r_status;

    logic          w_fire;
    logic          w_in_range;
    logic [7:0]    w_b;
    logic [2:0]    w_hsize;
    logic [7:0]    w_path_bytes;
    logic          w_path_bad;
    logic [7:0]    w_left_dec;
    logic          w_hdr_bad_ver;
    logic          w_hdr_transport;
    t_status       w_status;
    logic [2:0]    w_role;

    assign w_fire = i_beat.valid && (!r_out_valid || !i_out_stall);
    assign o_take = w_fire;

    assign w_b        = i_beat.byte_value;
    assign w_in_range = r_byte_total < TW'(MAX_PACKET_BYTES);

    assign w_hsize      = {1'b0, w_b[7:6]} + 3'd1;
    assign w_path_bytes = 8'({2'b00, w_b[5:0]} * {5'b00000, w_hsize});
    assign w_path_bad   = (w_b[7:6] == HASH_SIZE_BAD) || (w_path_bytes > i_max_path_bytes);
    assign w_left_dec   = (r_path_left != 8'd0) ? (r_path_left - 8'd1) : 8'd0;

    assign w_hdr_bad_ver   = w_b[7:6] != VERSION_SUPPORTED;
    assign w_hdr_transport = (w_b[1:0] == ROUTE_TRANSPORT_A) || (w_b[1:0] == ROUTE_TRANSPORT_B);

    assign w_role = w_in_range ? 3'(r_phase) : 3'(PH_DISCARD);

    // Status of a final byte follows the phase it arrives in.
    always_comb begin
        unique case (r_phase)
            PH_HEADER, PH_TRANSPORT: w_status = ST_SHORT;
            PH_PATHLEN, PH_PATH:     w_status = ST_BADPATH;
            PH_PAYLOAD:              w_status = ST_OK;
            default:                 w_status = r_pending;
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_in_range) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (w_hdr_bad_ver) begin
                        n_phase = PH_DISCARD;
                    end else if (w_hdr_transport) begin
                        n_phase = PH_TRANSPORT;
                    end else begin
                        n_phase = PH_PATHLEN;
                    end
                end
                PH_TRANSPORT: begin
                    // Transport bytes sit at indexes one to four; four ends the field.
                    if (r_byte_total[1:0] == 2'd0) begin
                        n_phase = PH_PATHLEN;
                    end
                end
                PH_PATHLEN: begin
                    if (w_path_bad) begin
                        n_phase = PH_DISCARD;
                    end else if (w_path_bytes != 8'd0) begin
                        n_phase = PH_PATH;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PATH: begin
                    if (w_left_dec == 8'd0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
        if (i_beat.packet_end) begin
            n_phase = PH_HEADER;
        end
    end

    // Held fields and counters
    always_comb begin
        n_byte_total = r_byte_total;
        n_header     = r_header;
        n_code_one   = r_code_one;
        n_code_two   = r_code_two;
        n_path_len   = r_path_len;
        n_path_left  = r_path_left;
        n_pending    = r_pending;
        if (w_in_range) begin
            n_byte_total = r_byte_total + TW'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    n_header    = w_b;
                    n_code_one  = 16'd0;
                    n_code_two  = 16'd0;
                    n_path_len  = 8'd0;
                    n_path_left = 8'd0;
                    n_pending   = w_hdr_bad_ver ? ST_VERSION : ST_OK;
                end
                PH_TRANSPORT: begin
                    unique case (r_byte_total[1:0])
                        2'd1:    n_code_one[7:0]  = w_b;
                        2'd2:    n_code_one[15:8] = w_b;
                        2'd3:    n_code_two[7:0]  = w_b;
                        default: n_code_two[15:8] = w_b;
                    endcase
                end
                PH_PATHLEN: begin
                    n_path_len = w_b;
                    if (w_path_bad) begin
                        n_pending = ST_BADPATH;
                    end else begin
                        n_path_left = w_path_bytes;
                    end
                end
                PH_PATH: begin
                    n_path_left = w_left_dec;
                end
                default: n_pending = r_pending;
            endcase
        end
        if (i_beat.packet_end) begin
            n_byte_total = '0;
            n_pending    = ST_OK;
            n_path_left  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_total <= '0;
            r_header     <= 8'd0;
            r_code_one   <= 16'd0;
            r_code_two   <= 16'd0;
            r_path_len   <= 8'd0;
            r_path_left  <= 8'd0;
            r_pending    <= ST_OK;
        end else if (w_fire) begin
            r_phase      <= n_phase;
            r_byte_total <= n_byte_total;
            r_header     <= n_header;
            r_code_one   <= n_code_one;
            r_code_two   <= n_code_two;
            r_path_len   <= n_path_len;
            r_path_left  <= n_path_left;
            r_pending    <= n_pending;
        end
    end

    always_comb begin
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_role   <= w_role;
            r_byte   <= w_b;
            r_end    <= i_beat.packet_end;
            r_status <= i_beat.packet_end ? w_status : ST_OK;
        end
    end

    // Held fields change only when a new result is loaded, so they match it.
    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_role;
    assign o_byte_out     = r_byte;
    assign o_route_kind   = r_header[1:0];
    assign o_payload_kind = r_header[5:2];
    assign o_hash_count   = r_path_len[5:0];
    assign o_hash_size    = {1'b0, r_path_len[7:6]} + 3'd1;
    assign o_code_one     = r_code_one;
    assign o_code_two     = r_code_two;
    assign o_frame_done   = r_end;
    assign o_status       = r_status;

endmodule

@@ src/mesh_packet_header_parser_top.sv @@
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+--------------------------------------
// in       | input     | i_in_valid / o_in_stall     | i_byte_value, i_packet_end
// out      | output    | o_out_valid / i_out_stall   | o_byte_role .. o_status (10 fields)
// cfg      | input     | i_cfg_valid / o_cfg_ready   | i_cfg_data (max_path_bytes)
//
// One byte per cycle sustained while i_out_stall is low: an input register feeds a
// combinational parse into a result register. An accepted byte is captured in the input
// register, then parsed and loaded into the result register as its output transaction.
// The input register still takes a byte while a result waits under i_out_stall, until
// both registers are full.
// Reset (i_rst_n low, synchronous) returns to the header phase with all holds cleared
// and max_path_bytes = 64. No clearing pass is needed.
module mesh_packet_header_parser_top import mphp_pkg::*; #(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_packet_end,
    // tagged byte output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_byte_role,
    output logic [7:0]  o_byte_out,
    output logic [1:0]  o_route_kind,
    output logic [3:0]  o_payload_kind,
    output logic [5:0]  o_hash_count,
    output logic [2:0]  o_hash_size,
    output logic [15:0] o_code_one,
    output logic [15:0] o_code_two,
    output logic        o_frame_done,
    output logic [1:0]  o_status,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    t_beat      w_beat;
    logic       w_take;
    logic [7:0] r_max_path_bytes;

    // The limit register takes any write, unchecked; the user must write only while idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_path_bytes <= MAX_PATH_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_path_bytes <= i_cfg_data;
        end
    end

    // Capture the incoming byte transaction.
    mphp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_packet_end (i_packet_end),
        .i_take       (w_take),
        .o_beat       (w_beat)
    );

    // Parse the held byte, advance the phase and load the result register.
    mphp_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_beat           (w_beat),
        .o_take           (w_take),
        .i_max_path_bytes (r_max_path_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_byte_role      (o_byte_role),
        .o_byte_out       (o_byte_out),
        .o_route_kind     (o_route_kind),
        .o_payload_kind   (o_payload_kind),
        .o_hash_count     (o_hash_count),
        .o_hash_size      (o_hash_size),
        .o_code_one       (o_code_one),
        .o_code_two       (o_code_two),
        .o_frame_done     (o_frame_done),
        .o_status         (o_status)
    );

    // Status reads zero except on the final byte of a packet.
    a_status_only_on_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (o_status == ST_OK)
    ) else $error("status set on a byte that is not final");

    // A header byte starts a packet with cleared codes and path length.
    a_header_clears_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_role == PH_HEADER)) |->
            (o_code_one == 16'd0 && o_code_two == 16'd0 &&
             o_hash_count == 6'd0 && o_hash_size == 3'd1)
    ) else $error("holds not cleared on header byte");

    // A packet ending in its payload is good.
    a_payload_end_ok: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done && (o_byte_role == PH_PAYLOAD)) |->
            (o_status == ST_OK)
    ) else $error("bad status on a packet ending in payload");

endmodule
